// ===== rtl/sqa_pkg.sv =====
// shared types, codes and helpers for the shadow atlas quadtree allocator
// no dependencies; imported by sqa_front, sqa_engine, the top unit and the testbench
`default_nettype none

package sqa_pkg;

   localparam int MAX_LEVELS_DEF     = 5;
   localparam int FREE_PER_LEVEL_DEF = 256;
   localparam int LIGHT_SLOTS_DEF    = 64;
   localparam int RETIRE_SLOTS_DEF   = 64;

   localparam logic [1:0] CMD_ACQUIRE = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_COLLECT = 2'd2;
   localparam logic [1:0] CMD_LOOKUP  = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_NO_SPACE  = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam logic [0:0] CSR_ATLAS_LOG2 = 1'b0;
   localparam logic [0:0] CSR_MIN_LOG2   = 1'b1;

   localparam logic [3:0] ATLAS_LOG2_RST = 4'd12;
   localparam logic [3:0] MIN_LOG2_RST   = 4'd8;

   typedef struct packed {
      logic [1:0]  command;
      logic        light_valid;
      logic [15:0] light_id;
      logic [15:0] requested_resolution;
      logic [63:0] fence_value;
   } sqa_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [14:0] alloc_x;
      logic [14:0] alloc_y;
      logic [15:0] alloc_size;
      logic [6:0]  freed_count;
   } sqa_rsp_type;

   typedef struct packed {
      logic [3:0] atlas_log2;
      logic [3:0] min_eff;
   } sqa_cfg_type;

   typedef struct packed {
      logic [1:0]  command;
      logic        light_valid;
      logic [15:0] light_id;
      logic [63:0] fence_value;
      logic [3:0]  target;
   } sqa_job_type;

   typedef struct packed {
      logic [15:0] key;
      logic [14:0] x;
      logic [14:0] y;
      logic [15:0] size;
   } sqa_held_type;

   typedef struct packed {
      logic [14:0] x;
      logic [14:0] y;
      logic [15:0] size;
   } sqa_gone_type;

   typedef struct packed {
      logic [14:0] x;
      logic [14:0] y;
   } sqa_blk_type;

   // tree level for a block edge: rounded up to a power of two and clamped
   function automatic logic [3:0] level_of(input logic [15:0] res, input logic [3:0] asl,
                                           input logic [3:0] min_eff);
      logic [15:0] m;
      logic [4:0]  k;
      m = (res == 16'd0) ? 16'd0 : res - 16'd1;
      k = 5'd0;
      for (int b = 0; b < 16; b++) begin
         if (m[b]) k = 5'(b + 1);
      end
      if (k < {1'b0, min_eff}) k = {1'b0, min_eff};
      if (k > {1'b0, asl}) k = {1'b0, asl};
      return asl - k[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sqa_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module sqa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/sqa_front.sv =====
// front end: accepts commands, works out the target level, two entry queue
// depends on sqa_pkg
`default_nettype none

module sqa_front import sqa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire sqa_cfg_type cfg,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire sqa_req_type req_data,
   output logic             job_valid,
   input  wire logic        job_ready,
   output sqa_job_type      job
);

   sqa_job_type q_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   sqa_job_type enq;
   logic        push, pop;

   always_comb begin
      enq.command     = req_data.command;
      enq.light_valid = req_data.light_valid;
      enq.light_id    = req_data.light_id;
      enq.fence_value = req_data.fence_value;
      enq.target      = level_of(req_data.requested_resolution, cfg.atlas_log2, cfg.min_eff);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rp_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_valid && job_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= enq;
   end

endmodule

`default_nettype wire

// ===== rtl/sqa_engine.sv =====
// back end: sequencer over the free lists, allocation table and retire store
// depends on sqa_pkg and sqa_ram
`default_nettype none

module sqa_engine import sqa_pkg::*; #(
   parameter int MAX_LEVELS     = MAX_LEVELS_DEF,
   parameter int FREE_PER_LEVEL = FREE_PER_LEVEL_DEF,
   parameter int LIGHT_SLOTS    = LIGHT_SLOTS_DEF,
   parameter int RETIRE_SLOTS   = RETIRE_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        reinit,
   input  wire sqa_cfg_type cfg,
   input  wire logic        job_valid,
   output logic             job_ready,
   input  wire sqa_job_type job,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output sqa_rsp_type      rsp_data
);

   localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int FIDX_W  = $clog2(FREE_PER_LEVEL);
   localparam int FCNT_W  = $clog2(FREE_PER_LEVEL + 1);
   localparam int FDEPTH  = MAX_LEVELS * FREE_PER_LEVEL;
   localparam int FADDR_W = $clog2(FDEPTH);
   localparam int SLOT_W  = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
   localparam int SCNT_W  = $clog2(LIGHT_SLOTS + 1);
   localparam int RIDX_W  = (RETIRE_SLOTS > 1) ? $clog2(RETIRE_SLOTS) : 1;
   localparam int RCNT_W  = $clog2(RETIRE_SLOTS + 1);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_HSCAN   = 5'd1;
   localparam logic [4:0] S_HCMP    = 5'd2;
   localparam logic [4:0] S_HEVAL   = 5'd3;
   localparam logic [4:0] S_ASRC    = 5'd4;
   localparam logic [4:0] S_APOP    = 5'd5;
   localparam logic [4:0] S_ASPL    = 5'd6;
   localparam logic [4:0] S_AFIN    = 5'd7;
   localparam logic [4:0] S_RB_LVL  = 5'd8;
   localparam logic [4:0] S_RB_SRD  = 5'd9;
   localparam logic [4:0] S_RB_SCMP = 5'd10;
   localparam logic [4:0] S_RB_CRD  = 5'd11;
   localparam logic [4:0] S_RB_CWR  = 5'd12;
   localparam logic [4:0] S_RB_PUSH = 5'd13;
   localparam logic [4:0] S_COL_RD  = 5'd14;
   localparam logic [4:0] S_COL_EV  = 5'd15;
   localparam logic [4:0] S_DONE    = 5'd16;

   function automatic logic [FADDR_W-1:0] fa(input logic [LVL_W-1:0] l,
                                             input logic [FIDX_W-1:0] i);
      return FADDR_W'(l) * FADDR_W'(FREE_PER_LEVEL) + FADDR_W'(i);
   endfunction

   logic [4:0]             state_ff, state_in, ret_ff, ret_in;
   sqa_job_type            job_ff, job_in;
   logic [SCNT_W-1:0]      aidx_ff, aidx_in;
   logic                   hfound_ff, hfound_in, ffound_ff, ffound_in;
   logic [SLOT_W-1:0]      hslot_ff, hslot_in, fslot_ff, fslot_in;
   logic [14:0]            hx_ff, hx_in, hy_ff, hy_in;
   logic [15:0]            hsz_ff, hsz_in, res_ff, res_in;
   logic [LVL_W-1:0]       tgt_ff, tgt_in, blvl_ff, blvl_in;
   logic [14:0]            bx_ff, bx_in, by_ff, by_in;
   logic [3:0]             hit_ff, hit_in, self_ff, self_in;
   logic [FCNT_W-1:0]      hidx_ff [4];
   logic [FCNT_W-1:0]      hidx_in [4];
   logic [FCNT_W-1:0]      fidx_ff, fidx_in, widx_ff, widx_in;
   logic [1:0]             kid_ff, kid_in;
   logic [14:0]            ox_ff, ox_in, oy_ff, oy_in;
   logic [15:0]            osz_ff, osz_in;
   logic [2:0]             status_ff, status_in;
   logic [6:0]             freed_ff, freed_in;
   logic                   lost_ff, lost_in;
   logic [RCNT_W-1:0]      ridx_ff, ridx_in, rw_ff, rw_in, rc_ff, rc_in;
   logic [FCNT_W-1:0]      cnt_ff [MAX_LEVELS];
   logic [FCNT_W-1:0]      cnt_in [MAX_LEVELS];
   logic [LIGHT_SLOTS-1:0] valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sqa_rsp_type            rsp_ff, rsp_in;

   logic                   a_we, f_we, r_we;
   logic [SLOT_W-1:0]      a_waddr, a_raddr;
   logic [FADDR_W-1:0]     f_waddr, f_raddr;
   logic [RIDX_W-1:0]      r_waddr, r_raddr;
   sqa_held_type           a_wdata, a_rd;
   sqa_blk_type            f_wdata, f_rd;
   sqa_gone_type           rb_wdata, rb_rd;
   logic [63:0]            rf_wdata, rf_rd;

   logic [15:0]            atlas_sz, bs, pmask;
   logic [14:0]            px, py, bs15;
   sqa_blk_type            sib [4];
   logic [3:0]             self_v;
   logic [FCNT_W-1:0]      cur_cnt, src_cnt;
   logic [LVL_W-1:0]       src_l;
   logic                   src_ok, split_full, drop;

   sqa_ram #(.WIDTH($bits(sqa_held_type)), .DEPTH(LIGHT_SLOTS)) u_alloc_ram (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
      .raddr(a_raddr), .rdata(a_rd)
   );

   sqa_ram #(.WIDTH($bits(sqa_blk_type)), .DEPTH(FDEPTH)) u_free_ram (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rd)
   );

   sqa_ram #(.WIDTH($bits(sqa_gone_type)), .DEPTH(RETIRE_SLOTS)) u_retire_ram (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(rb_wdata),
      .raddr(r_raddr), .rdata(rb_rd)
   );

   sqa_ram #(.WIDTH(64), .DEPTH(RETIRE_SLOTS)) u_fence_ram (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(rf_wdata),
      .raddr(r_raddr), .rdata(rf_rd)
   );

   // geometry of the block under merge and its siblings
   always_comb begin
      atlas_sz = 16'd1 << cfg.atlas_log2;
      bs       = atlas_sz >> blvl_ff;
      bs15     = bs[14:0];
      pmask    = ~((bs << 1) - 16'd1);
      px       = bx_ff & pmask[14:0];
      py       = by_ff & pmask[14:0];
      sib[0]   = '{x: px,        y: py};
      sib[1]   = '{x: px + bs15, y: py};
      sib[2]   = '{x: px,        y: py + bs15};
      sib[3]   = '{x: px + bs15, y: py + bs15};
      self_v   = 4'd1 << {((by_ff & bs15) != '0), ((bx_ff & bs15) != '0)};
      cur_cnt  = cnt_ff[blvl_ff];
   end

   // source level for a split and room on the split path
   always_comb begin
      src_l      = '0;
      src_ok     = 1'b0;
      src_cnt    = '0;
      split_full = 1'b0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
         if (LVL_W'(l) <= tgt_ff && cnt_ff[l] != '0) begin
            src_l   = LVL_W'(l);
            src_ok  = 1'b1;
            src_cnt = cnt_ff[l];
         end
      end
      for (int l = 0; l < MAX_LEVELS; l++) begin
         if (LVL_W'(l) > src_l && LVL_W'(l) <= tgt_ff &&
             int'(cnt_ff[l]) + 3 > FREE_PER_LEVEL) split_full = 1'b1;
      end
   end

   always_comb begin
      drop = 1'b0;
      for (int j = 0; j < 4; j++) begin
         if (hit_ff[j] && !self_ff[j] && hidx_ff[j] == fidx_ff) drop = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      job_in       = job_ff;
      aidx_in      = aidx_ff;
      hfound_in    = hfound_ff;
      ffound_in    = ffound_ff;
      hslot_in     = hslot_ff;
      fslot_in     = fslot_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      hsz_in       = hsz_ff;
      res_in       = res_ff;
      tgt_in       = tgt_ff;
      blvl_in      = blvl_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      hit_in       = hit_ff;
      self_in      = self_ff;
      hidx_in      = hidx_ff;
      fidx_in      = fidx_ff;
      widx_in      = widx_ff;
      kid_in       = kid_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      osz_in       = osz_ff;
      status_in    = status_ff;
      freed_in     = freed_ff;
      lost_in      = lost_ff;
      ridx_in      = ridx_ff;
      rw_in        = rw_ff;
      rc_in        = rc_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff;
      job_ready    = 1'b0;

      a_we     = 1'b0;
      a_waddr  = hslot_ff;
      a_wdata  = '{key: job_ff.light_id, x: ox_ff, y: oy_ff, size: res_ff};
      a_raddr  = aidx_ff[SLOT_W-1:0];
      f_we     = 1'b0;
      f_waddr  = fa(blvl_ff, cur_cnt[FIDX_W-1:0]);
      f_wdata  = '{x: bx_ff, y: by_ff};
      f_raddr  = fa(blvl_ff, fidx_ff[FIDX_W-1:0]);
      r_we     = 1'b0;
      r_waddr  = rc_ff[RIDX_W-1:0];
      rb_wdata = '{x: hx_ff, y: hy_ff, size: hsz_ff};
      rf_wdata = job_ff.fence_value;
      r_raddr  = ridx_ff[RIDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (job_valid && (!rsp_valid_ff || rsp_ready)) begin
               job_ready = 1'b1;
               job_in    = job;
               status_in = ST_OK;
               ox_in     = '0;
               oy_in     = '0;
               osz_in    = '0;
               freed_in  = '0;
               lost_in   = 1'b0;
               aidx_in   = '0;
               hfound_in = 1'b0;
               ffound_in = 1'b0;
               ridx_in   = '0;
               rw_in     = '0;
               tgt_in    = LVL_W'(job.target);
               res_in    = atlas_sz >> job.target;
               priority if (job.command == CMD_ACQUIRE && !job.light_valid) begin
                  status_in = ST_INVALID;
                  state_in  = S_DONE;
               end else if (job.command == CMD_COLLECT) begin
                  state_in = S_COL_RD;
               end else begin
                  state_in = S_HSCAN;
               end
            end
         end
         S_HSCAN: begin
            if (aidx_ff == SCNT_W'(LIGHT_SLOTS)) begin
               state_in = S_HEVAL;
            end else if (valid_ff[aidx_ff[SLOT_W-1:0]]) begin
               state_in = S_HCMP;
            end else begin
               if (!ffound_ff) begin
                  ffound_in = 1'b1;
                  fslot_in  = aidx_ff[SLOT_W-1:0];
               end
               aidx_in = aidx_ff + SCNT_W'(1);
            end
         end
         S_HCMP: begin
            if (a_rd.key == job_ff.light_id) begin
               hfound_in = 1'b1;
               hslot_in  = aidx_ff[SLOT_W-1:0];
               hx_in     = a_rd.x;
               hy_in     = a_rd.y;
               hsz_in    = a_rd.size;
               state_in  = S_HEVAL;
            end else begin
               aidx_in  = aidx_ff + SCNT_W'(1);
               state_in = S_HSCAN;
            end
         end
         S_HEVAL: begin
            state_in = S_DONE;
            unique case (job_ff.command)
               CMD_LOOKUP: begin
                  if (hfound_ff) begin
                     ox_in  = hx_ff;
                     oy_in  = hy_ff;
                     osz_in = hsz_ff;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               CMD_RELEASE: begin
                  priority if (!hfound_ff) begin
                     status_in = ST_NOT_FOUND;
                  end else if (int'(rc_ff) >= RETIRE_SLOTS) begin
                     status_in = ST_FULL;
                  end else begin
                     r_we               = 1'b1;
                     rc_in              = rc_ff + RCNT_W'(1);
                     valid_in[hslot_ff] = 1'b0;
                     ox_in              = hx_ff;
                     oy_in              = hy_ff;
                     osz_in             = hsz_ff;
                  end
               end
               CMD_ACQUIRE: begin
                  priority if (hfound_ff && hsz_ff == res_ff) begin
                     ox_in  = hx_ff;
                     oy_in  = hy_ff;
                     osz_in = hsz_ff;
                  end else if (hfound_ff) begin
                     valid_in[hslot_ff] = 1'b0;
                     bx_in    = hx_ff;
                     by_in    = hy_ff;
                     blvl_in  = LVL_W'(level_of(hsz_ff, cfg.atlas_log2, cfg.min_eff));
                     ret_in   = S_ASRC;
                     state_in = S_RB_LVL;
                  end else if (!ffound_ff) begin
                     status_in = ST_FULL;
                  end else begin
                     hslot_in = fslot_ff;
                     state_in = S_ASRC;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_ASRC: begin
            priority if (!src_ok) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else if (split_full) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               cnt_in[src_l] = src_cnt - FCNT_W'(1);
               f_raddr       = fa(src_l, FIDX_W'(src_cnt - FCNT_W'(1)));
               blvl_in       = src_l;
               state_in      = S_APOP;
            end
         end
         S_APOP: begin
            ox_in = f_rd.x;
            oy_in = f_rd.y;
            if (blvl_ff == tgt_ff) begin
               state_in = S_AFIN;
            end else begin
               blvl_in  = blvl_ff + LVL_W'(1);
               kid_in   = 2'd0;
               state_in = S_ASPL;
            end
         end
         S_ASPL: begin
            f_we            = 1'b1;
            f_wdata.x       = (kid_ff == 2'd1) ? ox_ff : ox_ff + bs15;
            f_wdata.y       = (kid_ff == 2'd0) ? oy_ff : oy_ff + bs15;
            cnt_in[blvl_ff] = cur_cnt + FCNT_W'(1);
            if (kid_ff == 2'd2) begin
               if (blvl_ff == tgt_ff) begin
                  state_in = S_AFIN;
               end else begin
                  blvl_in = blvl_ff + LVL_W'(1);
                  kid_in  = 2'd0;
               end
            end else begin
               kid_in = kid_ff + 2'd1;
            end
         end
         S_AFIN: begin
            a_we               = 1'b1;
            valid_in[hslot_ff] = 1'b1;
            osz_in             = res_ff;
            if (lost_ff) status_in = ST_FULL;
            state_in = S_DONE;
         end
         S_RB_LVL: begin
            if (blvl_ff == '0) begin
               state_in = S_RB_PUSH;
            end else begin
               hit_in   = self_v;
               self_in  = self_v;
               fidx_in  = '0;
               state_in = S_RB_SRD;
            end
         end
         S_RB_SRD: begin
            if (fidx_ff == cur_cnt) begin
               if (&hit_ff) begin
                  fidx_in  = '0;
                  widx_in  = '0;
                  state_in = S_RB_CRD;
               end else begin
                  state_in = S_RB_PUSH;
               end
            end else begin
               state_in = S_RB_SCMP;
            end
         end
         S_RB_SCMP: begin
            for (int j = 0; j < 4; j++) begin
               if (!hit_ff[j] && f_rd == sib[j]) begin
                  hit_in[j]  = 1'b1;
                  hidx_in[j] = fidx_ff;
               end
            end
            fidx_in  = fidx_ff + FCNT_W'(1);
            state_in = S_RB_SRD;
         end
         S_RB_CRD: begin
            if (fidx_ff == cur_cnt) begin
               cnt_in[blvl_ff] = widx_ff;
               bx_in           = px;
               by_in           = py;
               blvl_in         = blvl_ff - LVL_W'(1);
               state_in        = S_RB_LVL;
            end else begin
               state_in = S_RB_CWR;
            end
         end
         S_RB_CWR: begin
            if (!drop) begin
               f_we    = 1'b1;
               f_waddr = fa(blvl_ff, widx_ff[FIDX_W-1:0]);
               f_wdata = f_rd;
               widx_in = widx_ff + FCNT_W'(1);
            end
            fidx_in  = fidx_ff + FCNT_W'(1);
            state_in = S_RB_CRD;
         end
         S_RB_PUSH: begin
            if (int'(cur_cnt) >= FREE_PER_LEVEL) begin
               lost_in = 1'b1;
            end else begin
               f_we            = 1'b1;
               cnt_in[blvl_ff] = cur_cnt + FCNT_W'(1);
            end
            state_in = ret_ff;
         end
         S_COL_RD: begin
            if (ridx_ff == rc_ff) begin
               rc_in = rw_ff;
               if (lost_ff) status_in = ST_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_COL_EV;
            end
         end
         S_COL_EV: begin
            ridx_in = ridx_ff + RCNT_W'(1);
            if (rf_rd > job_ff.fence_value) begin
               r_we     = 1'b1;
               r_waddr  = rw_ff[RIDX_W-1:0];
               rb_wdata = rb_rd;
               rf_wdata = rf_rd;
               rw_in    = rw_ff + RCNT_W'(1);
               state_in = S_COL_RD;
            end else begin
               bx_in    = rb_rd.x;
               by_in    = rb_rd.y;
               blvl_in  = LVL_W'(level_of(rb_rd.size, cfg.atlas_log2, cfg.min_eff));
               ret_in   = S_COL_RD;
               if (freed_ff != 7'd127) freed_in = freed_ff + 7'd1;
               state_in = S_RB_LVL;
            end
         end
         S_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = status_ff;
            rsp_in.alloc_x     = ox_ff;
            rsp_in.alloc_y     = oy_ff;
            rsp_in.alloc_size  = osz_ff;
            rsp_in.freed_count = freed_ff;
            state_in           = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (reinit) begin
         for (int l = 0; l < MAX_LEVELS; l++) cnt_in[l] = '0;
         cnt_in[0] = FCNT_W'(1);
         valid_in  = '0;
         rc_in     = '0;
      end

      // whole atlas block at the origin of level zero
      if (reset || reinit) begin
         f_we    = 1'b1;
         f_waddr = '0;
         f_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         for (int l = 0; l < MAX_LEVELS; l++) cnt_ff[l] <= '0;
         cnt_ff[0]    <= FCNT_W'(1);
         valid_ff     <= '0;
         rc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;
      job_ff    <= job_in;
      aidx_ff   <= aidx_in;
      hfound_ff <= hfound_in;
      ffound_ff <= ffound_in;
      hslot_ff  <= hslot_in;
      fslot_ff  <= fslot_in;
      hx_ff     <= hx_in;
      hy_ff     <= hy_in;
      hsz_ff    <= hsz_in;
      res_ff    <= res_in;
      tgt_ff    <= tgt_in;
      blvl_ff   <= blvl_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      hit_ff    <= hit_in;
      self_ff   <= self_in;
      hidx_ff   <= hidx_in;
      fidx_ff   <= fidx_in;
      widx_ff   <= widx_in;
      kid_ff    <= kid_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      osz_ff    <= osz_in;
      status_ff <= status_in;
      freed_ff  <= freed_in;
      lost_ff   <= lost_in;
      ridx_ff   <= ridx_in;
      rw_ff     <= rw_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/shadow_atlas_quadtree_allocator_unit.sv =====
// lookup and release run as long as the allocation table scan lasts
// acquire adds work per free list entry and level on a merge pass, and per split level
// collect adds work per retired entry plus the merge passes; one command in the back end at once
// two entry input queue and a result register, so a new command is taken while a result waits
// synchronous reset, and every configuration write, empties the allocator
// depends on sqa_pkg, sqa_front, sqa_engine and sqa_ram
`default_nettype none

module shadow_atlas_quadtree_allocator_unit import sqa_pkg::*; #(
   parameter int MAX_LEVELS     = MAX_LEVELS_DEF,
   parameter int FREE_PER_LEVEL = FREE_PER_LEVEL_DEF,
   parameter int LIGHT_SLOTS    = LIGHT_SLOTS_DEF,
   parameter int RETIRE_SLOTS   = RETIRE_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [3:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire sqa_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output sqa_rsp_type      rsp_data
);

   logic [3:0]  asl_ff, asl_in, minl_ff, minl_in;
   logic [3:0]  me_clamp;
   sqa_cfg_type cfg;
   logic        job_valid, job_ready;
   sqa_job_type job;

   always_comb begin
      asl_in  = asl_ff;
      minl_in = minl_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ATLAS_LOG2: asl_in  = csr_wdata;
            CSR_MIN_LOG2:   minl_in = csr_wdata;
            default:        asl_in  = asl_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asl_ff  <= ATLAS_LOG2_RST;
         minl_ff <= MIN_LOG2_RST;
      end else begin
         asl_ff  <= asl_in;
         minl_ff <= minl_in;
      end
   end

   always_comb begin
      me_clamp = (minl_ff > asl_ff) ? asl_ff : minl_ff;
      if (asl_ff - me_clamp > 4'(MAX_LEVELS - 1)) me_clamp = asl_ff - 4'(MAX_LEVELS - 1);
      cfg.atlas_log2 = asl_ff;
      cfg.min_eff    = me_clamp;
   end

   sqa_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   sqa_engine #(
      .MAX_LEVELS(MAX_LEVELS), .FREE_PER_LEVEL(FREE_PER_LEVEL),
      .LIGHT_SLOTS(LIGHT_SLOTS), .RETIRE_SLOTS(RETIRE_SLOTS)
   ) u_engine (
      .clock(clock), .reset(reset), .reinit(csr_we), .cfg(cfg),
      .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= ST_FULL))
      else $error("result status out of range");

   a_size_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_data.alloc_size))
      else $error("block edge not a power of two");

   a_invalid_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_INVALID) |->
         (rsp_data.alloc_size == '0 && rsp_data.freed_count == '0))
      else $error("invalid light result carries data");

endmodule

`default_nettype wire

// ===== dv/tb_shadow_atlas_quadtree_allocator_unit.sv =====
// self-checking testbench for the shadow atlas quadtree allocator unit
// drives directed and random commands over several atlas settings and checks every result
// against fixed expectations or a behavioural allocator model kept here; depends on sqa_pkg and the unit itself
`timescale 1ns / 100ps
`default_nettype none

module tb_shadow_atlas_quadtree_allocator_unit;
   import sqa_pkg::*;

   localparam int NLEV  = MAX_LEVELS_DEF;
   localparam int NFREE = FREE_PER_LEVEL_DEF;
   localparam int NHELD = LIGHT_SLOTS_DEF;
   localparam int NGONE = RETIRE_SLOTS_DEF;
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [3:0]  csr_wdata;
   logic        req_valid;
   logic        req_ready;
   sqa_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   sqa_rsp_type rsp_data;

   shadow_atlas_quadtree_allocator_unit DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // allocator model state
   int unsigned atlas_log2, min_log2, min_eff;
   int unsigned free_x[NLEV][NFREE], free_y[NLEV][NFREE], free_n[NLEV];
   bit          held_v[NHELD];
   int unsigned held_key[NHELD], held_x[NHELD], held_y[NHELD], held_sz[NHELD];
   int unsigned gone_x[NGONE], gone_y[NGONE], gone_sz[NGONE];
   logic [63:0] gone_fence[NGONE];
   int unsigned gone_n;

   sqa_rsp_type expected_rsp_q[$];
   int unsigned items_sent, results_seen, mismatches, errors, phases_run;
   int unsigned hold_asked, hold_given, idle_cycles;
   bit          quiet, done;

   function automatic void clear_atlas();
      min_eff = (min_log2 > atlas_log2) ? atlas_log2 : min_log2;
      if (atlas_log2 - min_eff > NLEV - 1) min_eff = atlas_log2 - (NLEV - 1);
      for (int l = 0; l < NLEV; l++) free_n[l] = 0;
      for (int i = 0; i < NHELD; i++) held_v[i] = 1'b0;
      gone_n = 0;
      free_x[0][0] = 0;
      free_y[0][0] = 0;
      free_n[0] = 1;
   endfunction

   function automatic int unsigned tree_level(int unsigned res);
      int unsigned k;
      k = 0;
      if (res == 0) res = 1;
      while (k < 17 && (1 << k) < res) k++;
      if (k < min_eff) k = min_eff;
      if (k > atlas_log2) k = atlas_log2;
      return atlas_log2 - k;
   endfunction

   function automatic int find_free(int unsigned lv, int unsigned x, int unsigned y);
      for (int i = 0; i < free_n[lv]; i++)
         if (free_x[lv][i] == x && free_y[lv][i] == y) return i;
      return -1;
   endfunction

   function automatic int find_light(int unsigned key);
      for (int i = 0; i < NHELD; i++)
         if (held_v[i] && held_key[i] == key) return i;
      return -1;
   endfunction

   // returns 0 when the free list had no room and the block is lost
   function automatic bit free_block(int unsigned x, int unsigned y, int unsigned sz);
      int unsigned lv, bs, px, py, w;
      int unsigned sx[4], sy[4];
      int hit[3];
      int n, f;
      lv = tree_level(sz);
      while (lv > 0) begin
         bs = (1 << atlas_log2) >> lv;
         px = x & ~(2 * bs - 1);
         py = y & ~(2 * bs - 1);
         sx = '{px, px + bs, px, px + bs};
         sy = '{py, py, py + bs, py + bs};
         n = 0;
         for (int s = 0; s < 4; s++) begin
            if (sx[s] == x && sy[s] == y) continue;
            f = find_free(lv, sx[s], sy[s]);
            if (f < 0 || n >= 3) begin
               n = -1;
               break;
            end
            hit[n] = f;
            n++;
         end
         if (n != 3) break;
         w = 0;
         for (int i = 0; i < free_n[lv]; i++) begin
            if (i == hit[0] || i == hit[1] || i == hit[2]) continue;
            free_x[lv][w] = free_x[lv][i];
            free_y[lv][w] = free_y[lv][i];
            w++;
         end
         free_n[lv] = w;
         x = px;
         y = py;
         lv--;
      end
      if (free_n[lv] >= NFREE) return 1'b0;
      free_x[lv][free_n[lv]] = x;
      free_y[lv][free_n[lv]] = y;
      free_n[lv]++;
      return 1'b1;
   endfunction

   function automatic sqa_rsp_type allocate_step(sqa_req_type rq);
      sqa_rsp_type r;
      int slot;
      int unsigned target, res, src, w, freed, cs;
      bit lost;
      r = '0;
      freed = 0;
      lost = 1'b0;
      slot = find_light(rq.light_id);
      case (rq.command)
         CMD_ACQUIRE: begin
            if (!rq.light_valid) begin
               r.status = ST_INVALID;
               return r;
            end
            target = tree_level(rq.requested_resolution);
            res = (1 << atlas_log2) >> target;
            if (slot >= 0) begin
               if (held_sz[slot] == res) begin
                  r.alloc_x = 15'(held_x[slot]);
                  r.alloc_y = 15'(held_y[slot]);
                  r.alloc_size = 16'(held_sz[slot]);
                  return r;
               end
               if (!free_block(held_x[slot], held_y[slot], held_sz[slot])) lost = 1'b1;
               held_v[slot] = 1'b0;
            end else begin
               for (int i = 0; i < NHELD; i++)
                  if (!held_v[i]) begin
                     slot = i;
                     break;
                  end
               if (slot < 0) begin
                  r.status = ST_FULL;
                  return r;
               end
            end
            src = target;
            while (src > 0 && free_n[src] == 0) src--;
            if (free_n[src] == 0) begin
               r.status = ST_NO_SPACE;
               return r;
            end
            for (int unsigned l = src + 1; l <= target; l++)
               if (free_n[l] + 3 > NFREE) begin
                  r.status = ST_FULL;
                  return r;
               end
            free_n[src]--;
            r.alloc_x = 15'(free_x[src][free_n[src]]);
            r.alloc_y = 15'(free_y[src][free_n[src]]);
            while (src < target) begin
               src++;
               cs = (1 << atlas_log2) >> src;
               free_x[src][free_n[src]] = r.alloc_x + cs;
               free_y[src][free_n[src]] = 32'(r.alloc_y);
               free_x[src][free_n[src] + 1] = 32'(r.alloc_x);
               free_y[src][free_n[src] + 1] = r.alloc_y + cs;
               free_x[src][free_n[src] + 2] = r.alloc_x + cs;
               free_y[src][free_n[src] + 2] = r.alloc_y + cs;
               free_n[src] += 3;
            end
            r.alloc_size = 16'(res);
            held_v[slot] = 1'b1;
            held_key[slot] = 32'(rq.light_id);
            held_x[slot] = 32'(r.alloc_x);
            held_y[slot] = 32'(r.alloc_y);
            held_sz[slot] = res;
            if (lost) r.status = ST_FULL;
         end
         CMD_RELEASE: begin
            if (slot < 0) begin
               r.status = ST_NOT_FOUND;
               return r;
            end
            if (gone_n >= NGONE) begin
               r.status = ST_FULL;
               return r;
            end
            r.alloc_x = 15'(held_x[slot]);
            r.alloc_y = 15'(held_y[slot]);
            r.alloc_size = 16'(held_sz[slot]);
            gone_x[gone_n] = held_x[slot];
            gone_y[gone_n] = held_y[slot];
            gone_sz[gone_n] = held_sz[slot];
            gone_fence[gone_n] = rq.fence_value;
            gone_n++;
            held_v[slot] = 1'b0;
         end
         CMD_COLLECT: begin
            w = 0;
            for (int i = 0; i < gone_n; i++) begin
               if (gone_fence[i] > rq.fence_value) begin
                  gone_x[w] = gone_x[i];
                  gone_y[w] = gone_y[i];
                  gone_sz[w] = gone_sz[i];
                  gone_fence[w] = gone_fence[i];
                  w++;
                  continue;
               end
               if (!free_block(gone_x[i], gone_y[i], gone_sz[i])) r.status = ST_FULL;
               freed++;
            end
            gone_n = w;
            r.freed_count = 7'((freed > 127) ? 127 : freed);
         end
         default: begin
            if (slot < 0) begin
               r.status = ST_NOT_FOUND;
               return r;
            end
            r.alloc_x = 15'(held_x[slot]);
            r.alloc_y = 15'(held_y[slot]);
            r.alloc_size = 16'(held_sz[slot]);
         end
      endcase
      return r;
   endfunction

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_rsp_q.size() == 0) begin
            errors++;
            if (mismatches < 10)
               $display("unexpected result %p at %0t", rsp_data, $realtime);
            mismatches++;
         end else begin
            sqa_rsp_type e;
            e = expected_rsp_q.pop_front();
            if (e.status !== rsp_data.status || e.alloc_x !== rsp_data.alloc_x ||
                e.alloc_y !== rsp_data.alloc_y || e.alloc_size !== rsp_data.alloc_size ||
                e.freed_count !== rsp_data.freed_count) begin
               errors++;
               if (mismatches < 10)
                  $display("result %0d: expected %p, got %p", results_seen, e, rsp_data);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!done && idle_cycles > WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_asked != hold_given) begin
            hold_given = hold_asked;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_cmd(sqa_req_type rq, bit known, sqa_rsp_type typed);
      sqa_rsp_type p;
      req_data <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      p = allocate_step(rq);
      expected_rsp_q = {expected_rsp_q, (known ? typed : p)};
      items_sent++;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic set_atlas(int unsigned a, int unsigned m);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_ATLAS_LOG2;
      csr_wdata <= 4'(a);
      @(posedge clock);
      csr_index <= CSR_MIN_LOG2;
      csr_wdata <= 4'(m);
      @(posedge clock);
      csr_we <= 1'b0;
      atlas_log2 = a;
      min_log2 = m;
      clear_atlas();
   endtask

   function automatic sqa_req_type mk_req(logic [1:0] c, bit lv, int unsigned id,
                                          int unsigned res, logic [63:0] f);
      sqa_req_type rq;
      rq.command = c;
      rq.light_valid = lv;
      rq.light_id = 16'(id);
      rq.requested_resolution = 16'(res);
      rq.fence_value = f;
      return rq;
   endfunction

   function automatic sqa_rsp_type mk_rsp(logic [2:0] s, int unsigned x, int unsigned y,
                                          int unsigned sz, int unsigned fc);
      sqa_rsp_type r;
      r.status = s;
      r.alloc_x = 15'(x);
      r.alloc_y = 15'(y);
      r.alloc_size = 16'(sz);
      r.freed_count = 7'(fc);
      return r;
   endfunction

   typedef struct {
      sqa_req_type rq;
      bit          known;
      sqa_rsp_type rs;
   } directed_row_type;

   typedef struct {
      int unsigned atlas, minimum, count, key_span, collect_pct;
   } phase_type;

   initial begin
      directed_row_type rows[$];
      phase_type plan[$];
      sqa_rsp_type none;
      sqa_req_type rq;
      logic [63:0] ones, frame;
      int unsigned pick, res;

      csr_we <= 1'b0;
      csr_index <= CSR_ATLAS_LOG2;
      csr_wdata <= 4'd0;
      req_valid <= 1'b0;
      req_data <= '0;
      reset <= 1'b1;
      quiet = 1'b0;
      done = 1'b0;
      items_sent = 0;
      results_seen = 0;
      mismatches = 0;
      errors = 0;
      hold_asked = 0;
      hold_given = 0;
      idle_cycles = 0;
      phases_run = 0;
      atlas_log2 = ATLAS_LOG2_RST;
      min_log2 = MIN_LOG2_RST;
      clear_atlas();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ones = '1;
      none = '0;
      rows = '{
         '{mk_req(CMD_ACQUIRE, 0, 7, 64, 0), 1, mk_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{mk_req(CMD_LOOKUP, 1, 7, 0, 0), 1, mk_rsp(ST_NOT_FOUND, 0, 0, 0, 0)},
         '{mk_req(CMD_RELEASE, 1, 7, 0, 0), 1, mk_rsp(ST_NOT_FOUND, 0, 0, 0, 0)},
         '{mk_req(CMD_COLLECT, 0, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0)},
         '{mk_req(CMD_ACQUIRE, 1, 1, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 256, 0)},
         '{mk_req(CMD_ACQUIRE, 1, 1, 256, 0), 1, mk_rsp(ST_OK, 0, 0, 256, 0)},
         '{mk_req(CMD_ACQUIRE, 1, 1, 16'hFFFF, 0), 1, mk_rsp(ST_OK, 0, 0, 4096, 0)},
         '{mk_req(CMD_ACQUIRE, 1, 2, 1, 0), 1, mk_rsp(ST_NO_SPACE, 0, 0, 0, 0)},
         '{mk_req(CMD_RELEASE, 1, 1, 0, ones), 1, mk_rsp(ST_OK, 0, 0, 4096, 0)},
         '{mk_req(CMD_COLLECT, 1, 0, 0, ones - 1), 1, mk_rsp(ST_OK, 0, 0, 0, 0)},
         '{mk_req(CMD_COLLECT, 1, 0, 16'hFFFF, ones), 1, mk_rsp(ST_OK, 0, 0, 0, 1)},
         '{mk_req(CMD_LOOKUP, 1, 1, 0, 0), 1, mk_rsp(ST_NOT_FOUND, 0, 0, 0, 0)},
         '{mk_req(CMD_ACQUIRE, 1, 16'hFFFF, 257, 0), 0, none},
         '{mk_req(CMD_ACQUIRE, 1, 3, 1000, 0), 0, none},
         '{mk_req(CMD_ACQUIRE, 1, 4, 16'h8000, 0), 0, none},
         '{mk_req(CMD_LOOKUP, 0, 16'hFFFF, 16'hFFFF, ones), 0, none},
         '{mk_req(CMD_ACQUIRE, 1, 16'hFFFF, 100, 0), 0, none},
         '{mk_req(CMD_RELEASE, 1, 3, 0, 5), 0, none},
         '{mk_req(CMD_RELEASE, 1, 16'hFFFF, 0, 9), 0, none},
         '{mk_req(CMD_COLLECT, 1, 0, 0, 4), 0, none},
         '{mk_req(CMD_COLLECT, 1, 0, 0, 5), 0, none},
         '{mk_req(CMD_COLLECT, 1, 0, 0, 9), 0, none},
         '{mk_req(CMD_LOOKUP, 1, 3, 0, 0), 0, none}
      };
      foreach (rows[i]) send_cmd(rows[i].rq, rows[i].known, rows[i].rs);

      // atlas, minimum, transfers, key pool, collect share in percent
      plan = '{
         '{12, 8, 300, 12, 10}, '{0, 0, 100, 6, 10}, '{15, 15, 100, 6, 10},
         '{15, 0, 400, 100, 0}, '{4, 2, 200, 8, 10}, '{10, 15, 150, 8, 10},
         '{3, 0, 200, 10, 10}
      };
      frame = 64'd100;
      foreach (plan[p]) begin
         set_atlas(plan[p].atlas, plan[p].minimum);
         phases_run++;
         quiet = (p == plan.size() - 1);
         for (int n = 0; n < plan[p].count; n++) begin
            if (p == 0 && n == 100) hold_asked++;
            pick = $urandom_range(0, 99);
            res = $urandom_range(0, 16);
            res = (1 << res) + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 6) == 0) res = $urandom_range(0, 16'hFFFF);
            if (pick < plan[p].collect_pct) rq.command = CMD_COLLECT;
            else if (pick < 50) rq.command = CMD_ACQUIRE;
            else if (pick < 75) rq.command = CMD_RELEASE;
            else rq.command = CMD_LOOKUP;
            rq.light_valid = ($urandom_range(0, 19) != 0);
            rq.light_id = ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                          16'($urandom_range(0, plan[p].key_span - 1));
            rq.requested_resolution = 16'(res);
            frame += $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) rq.fence_value = {$urandom, $urandom};
            else if (rq.command == CMD_RELEASE) rq.fence_value = frame + $urandom_range(0, 3);
            else rq.fence_value = frame;
            send_cmd(rq, 1'b0, none);
         end
      end
      req_valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      done = 1'b1;
      $display("%0d commands over %0d atlas settings, %0d results checked",
               items_sent, phases_run + 1, results_seen);
      $display("covered acquire, release, collect and lookup incl. extremes and stalls");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/sqa_pkg.sv
rtl/sqa_ram.sv
rtl/sqa_front.sv
rtl/sqa_engine.sv
rtl/shadow_atlas_quadtree_allocator_unit.sv
dv/tb_shadow_atlas_quadtree_allocator_unit.sv
